FILE: hdl/rmsdb_pkg.sv
`default_nettype none

package rmsdb_pkg;

	// field widths
	localparam int LEVEL_W   = 32;
	localparam int FS_W      = 31;
	localparam int DB_W      = 12;
	localparam int M_TDATA_W = 16;
	localparam int CFG_IDX_W = 1;

	// highest set bit index of a 31-bit positive value
	localparam int TOP_W = 5;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 1'd1;

	localparam logic [FS_W-1:0] FS_RESET    = 31'd32767;
	localparam logic [DB_W-1:0] FLOOR_RESET = 12'hC18; // -1000

	// tenths of a dB per octave, as 60206 / 1000
	localparam int                DB10_NUM_W = 16;
	localparam logic [15:0]       DB10_NUM   = 16'd60206;
	localparam int                DB10_DEN   = 1000;

	// quotient before the divide by 1000 stays below 2^21
	localparam int Q_W = 21;
	// divide by 1000: q * ceil(2^31 / 1000) >> 31, exact for q < 2^21
	localparam int          RECIP_W     = 22;
	localparam logic [21:0] RECIP_K     = 22'd2147484;
	localparam int          RECIP_SHIFT = 31;
	// magnitude in tenths of a dB fits 11 bits
	localparam int MAGD_W = 11;

endpackage

`default_nettype wire

FILE: hdl/rmsdb_round.sv
`default_nettype none

// One squaring round of the log2 fraction: square the mantissa, renormalise
// to [1,2) and shift the resulting fraction bit in.
module rmsdb_round #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [FRAC_BITS:0]   mant_in,
	input  wire logic [FRAC_BITS-1:0] frac_in,
	output logic      [FRAC_BITS:0]   mant_q,
	output logic      [FRAC_BITS-1:0] frac_q
);

	localparam int M_W = FRAC_BITS + 1;

	logic [2*M_W-1:0] sq;
	logic [FRAC_BITS+1:0] t;
	logic [FRAC_BITS:0] mant_nxt;
	logic bit_nxt;

	always_comb begin
		sq = mant_in * mant_in;
		t  = sq[2*FRAC_BITS+1:FRAC_BITS];
		bit_nxt = t[FRAC_BITS+1];
		if (bit_nxt) begin
			mant_nxt = t[FRAC_BITS+1:1];
		end else begin
			mant_nxt = t[FRAC_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_q <= mant_nxt;
			frac_q <= {frac_in[FRAC_BITS-2:0], bit_nxt};
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rms_level_to_dbfs_tenths.sv
`default_nettype none

// Throughput: one item per cycle while the skid slot is empty; one squaring round
// per stage, both logs in parallel, so nothing is shared between items.
// A two-deep output (register plus skid) lets the pipeline run on while one
// result waits. Reset (arst_n low, asynchronous) empties the pipeline and
// loads full scale 32767 and floor -1000.
module rms_level_to_dbfs_tenths #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] level_value
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [11:0] dbfs_tenths, [15:12] zero
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	localparam int M_W    = FRAC_BITS + 1;
	localparam int TOP_W  = rmsdb_pkg::TOP_W;
	localparam int LOG_W  = TOP_W + FRAC_BITS;
	localparam int PROD_W = LOG_W + rmsdb_pkg::DB10_NUM_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int FS_W   = rmsdb_pkg::FS_W;
	localparam int DB_W   = rmsdb_pkg::DB_W;
	localparam int Q_W    = rmsdb_pkg::Q_W;
	localparam int K_W    = Q_W + rmsdb_pkg::RECIP_W;
	localparam int MAGD_W = rmsdb_pkg::MAGD_W;
	// half the divisor 2^FRAC_BITS * 1000, for round half up
	localparam logic [SUM_W-1:0] ROUND_C =
		SUM_W'(rmsdb_pkg::DB10_DEN / 2) << FRAC_BITS;

	function automatic logic [TOP_W-1:0] msb_idx(input logic [FS_W-1:0] v);
		logic [TOP_W-1:0] r;
		r = '0;
		for (int i = 0; i < FS_W; i++) begin
			if (v[i]) begin
				r = TOP_W'(i);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [FS_W-1:0] fs_q;
	logic [DB_W-1:0] floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= rmsdb_pkg::FS_RESET;
			floor_q <= rmsdb_pkg::FLOOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rmsdb_pkg::REG_FULL_SCALE: fs_q    <= cfg_data;
				rmsdb_pkg::REG_FLOOR:      floor_q <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline enable: the whole pipe moves unless the skid slot is full
	// ------------------------------------------------------------------
	logic en;
	logic skid_vld_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	// ------------------------------------------------------------------
	// s1: capture, pick out the floor cases, find the top set bits
	// ------------------------------------------------------------------
	logic              vld_s1;
	logic [FS_W-1:0]   lvl_s1;
	logic [FS_W-1:0]   fs_s1;
	logic [TOP_W-1:0]  topv_s1, topf_s1;
	logic              flr_s1;
	logic [DB_W-1:0]   floor_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s1   <= s_tdata[FS_W-1:0];
			fs_s1    <= fs_q;
			topv_s1  <= msb_idx(s_tdata[FS_W-1:0]);
			topf_s1  <= msb_idx(fs_q);
			// negative or zero reading, or a zero full scale
			flr_s1   <= s_tdata[31] || (s_tdata == '0) || (fs_q == '0);
			floor_s1 <= floor_q;
		end
	end

	// ------------------------------------------------------------------
	// s2: normalise both values to a mantissa in [1,2)
	// ------------------------------------------------------------------
	logic [FS_W-1:0] normv, normf;

	always_comb begin
		normv = lvl_s1 << (TOP_W'(FS_W - 1) - topv_s1);
		normf = fs_s1  << (TOP_W'(FS_W - 1) - topf_s1);
	end

	// round chain, index 0 is the s2 register
	logic                 rnd_vld   [0:FRAC_BITS];
	logic [M_W-1:0]       rnd_mv_s  [0:FRAC_BITS];
	logic [M_W-1:0]       rnd_mf_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] rnd_fv_s  [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] rnd_ff_s  [0:FRAC_BITS];
	logic [TOP_W-1:0]     rnd_topv_s[0:FRAC_BITS];
	logic [TOP_W-1:0]     rnd_topf_s[0:FRAC_BITS];
	logic                 rnd_flr_s [0:FRAC_BITS];
	logic [DB_W-1:0]      rnd_floor_s[0:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld[0] <= 1'b0;
		end else if (en) begin
			rnd_vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rnd_mv_s[0]    <= normv[FS_W-1 -: M_W];
			rnd_mf_s[0]    <= normf[FS_W-1 -: M_W];
			rnd_fv_s[0]    <= '0;
			rnd_ff_s[0]    <= '0;
			rnd_topv_s[0]  <= topv_s1;
			rnd_topf_s[0]  <= topf_s1;
			rnd_flr_s[0]   <= flr_s1;
			rnd_floor_s[0] <= floor_s1;
		end
	end

	// one squaring round per stage, one fraction bit each
	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_round
		rmsdb_round #(.FRAC_BITS(FRAC_BITS)) u_rnd_v (
			.clk     (clk),
			.en      (en),
			.mant_in (rnd_mv_s[g]),
			.frac_in (rnd_fv_s[g]),
			.mant_q  (rnd_mv_s[g+1]),
			.frac_q  (rnd_fv_s[g+1])
		);

		rmsdb_round #(.FRAC_BITS(FRAC_BITS)) u_rnd_f (
			.clk     (clk),
			.en      (en),
			.mant_in (rnd_mf_s[g]),
			.frac_in (rnd_ff_s[g]),
			.mant_q  (rnd_mf_s[g+1]),
			.frac_q  (rnd_ff_s[g+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rnd_vld[g+1] <= 1'b0;
			end else if (en) begin
				rnd_vld[g+1] <= rnd_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rnd_topv_s[g+1]  <= rnd_topv_s[g];
				rnd_topf_s[g+1]  <= rnd_topf_s[g];
				rnd_flr_s[g+1]   <= rnd_flr_s[g];
				rnd_floor_s[g+1] <= rnd_floor_s[g];
			end
		end
	end

	// ------------------------------------------------------------------
	// sd: octave difference as sign and magnitude
	// ------------------------------------------------------------------
	logic [LOG_W-1:0] lv, lf;
	logic             vld_sd, below_sd, flr_sd;
	logic [LOG_W-1:0] mag_sd;
	logic [DB_W-1:0]  floor_sd;

	assign lv = {rnd_topv_s[FRAC_BITS], rnd_fv_s[FRAC_BITS]};
	assign lf = {rnd_topf_s[FRAC_BITS], rnd_ff_s[FRAC_BITS]};

	// mantissas left after the last round are not needed
	logic unused_mant;
	assign unused_mant = ^{rnd_mv_s[FRAC_BITS], rnd_mf_s[FRAC_BITS]};

	always_ff @(posedge clk) begin
		if (en) begin
			below_sd <= lv < lf;
			mag_sd   <= (lv < lf) ? (lf - lv) : (lv - lf);
			flr_sd   <= rnd_flr_s[FRAC_BITS];
			floor_sd <= rnd_floor_s[FRAC_BITS];
		end
	end

	// ------------------------------------------------------------------
	// sm: scale by 60206
	// ------------------------------------------------------------------
	logic              vld_sm, below_sm, flr_sm;
	logic [PROD_W-1:0] prod_sm;
	logic [DB_W-1:0]   floor_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sm  <= PROD_W'(mag_sd) * PROD_W'(rmsdb_pkg::DB10_NUM);
			below_sm <= below_sd;
			flr_sm   <= flr_sd;
			floor_sm <= floor_sd;
		end
	end

	// ------------------------------------------------------------------
	// sq: add half the divisor, drop the fraction bits
	// ------------------------------------------------------------------
	logic             vld_sq, below_sq, flr_sq;
	logic [Q_W-1:0]   q_sq;
	logic [DB_W-1:0]  floor_sq;
	logic [SUM_W-1:0] rsum;

	assign rsum = SUM_W'(prod_sm) + ROUND_C;

	always_ff @(posedge clk) begin
		if (en) begin
			q_sq     <= Q_W'(rsum >> FRAC_BITS);
			below_sq <= below_sm;
			flr_sq   <= flr_sm;
			floor_sq <= floor_sm;
		end
	end

	// ------------------------------------------------------------------
	// sk: divide by 1000 through the reciprocal
	// ------------------------------------------------------------------
	logic              vld_sk, below_sk, flr_sk;
	logic [MAGD_W-1:0] r_sk;
	logic [DB_W-1:0]   floor_sk;
	logic [K_W-1:0]    kprod;

	assign kprod = K_W'(q_sq) * K_W'(rmsdb_pkg::RECIP_K);

	always_ff @(posedge clk) begin
		if (en) begin
			r_sk     <= kprod[rmsdb_pkg::RECIP_SHIFT +: MAGD_W];
			below_sk <= below_sq;
			flr_sk   <= flr_sq;
			floor_sk <= floor_sq;
		end
	end

	// ------------------------------------------------------------------
	// sf: restore the sign, choose the floor
	// ------------------------------------------------------------------
	logic            vld_sf;
	logic [DB_W-1:0] res_sf;

	always_ff @(posedge clk) begin
		if (en) begin
			if (flr_sk) begin
				res_sf <= floor_sk;
			end else if (below_sk) begin
				res_sf <= -DB_W'(r_sk);
			end else begin
				res_sf <= DB_W'(r_sk);
			end
		end
	end

	// valid bits of the tail stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd <= 1'b0;
			vld_sm <= 1'b0;
			vld_sq <= 1'b0;
			vld_sk <= 1'b0;
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sd <= rnd_vld[FRAC_BITS];
			vld_sm <= vld_sd;
			vld_sq <= vld_sm;
			vld_sk <= vld_sq;
			vld_sf <= vld_sk;
		end
	end

	// ------------------------------------------------------------------
	// output register with skid slot
	// ------------------------------------------------------------------
	logic            out_vld_q;
	logic [DB_W-1:0] out_q, skid_q;
	logic            take;

	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_sf) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (vld_sf) begin
			if (out_vld_q && !take) begin
				skid_q <= res_sf;
			end else begin
				out_q <= res_sf;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(rmsdb_pkg::M_TDATA_W - DB_W)'(0), out_q};

endmodule

`default_nettype wire

FILE: hdl/rmsdb_checker.sv
`default_nettype none

module rmsdb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input back-pressure only comes from a full output stage
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a full skid slot only drains through an output transfer
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && !m_tready |=> !s_tready)
		else $error("stall released without output transfer");

	// padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] == 4'd0))
		else $error("result padding not zero");

endmodule

bind rms_level_to_dbfs_tenths rmsdb_checker u_rmsdb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// field widths, as the block's package gives them
	localparam int LEVEL_W   = rmsdb_pkg::LEVEL_W;
	localparam int FS_W      = rmsdb_pkg::FS_W;
	localparam int DB_W      = rmsdb_pkg::DB_W;
	localparam int M_TDATA_W = rmsdb_pkg::M_TDATA_W;
	localparam int CFG_IDX_W = rmsdb_pkg::CFG_IDX_W;

	// log2 fraction bits, as the block's default parameter
	localparam int FRAC = 16;
	// tenths of a dB per octave is 60206 / 1000; the log difference carries FRAC
	// fraction bits, hence the scale of 2^FRAC * 1000
	localparam longint unsigned DB10_PER_OCTAVE = 60206;
	localparam longint unsigned DB10_SCALE      = 64'd65536000;
	// gives up after this many cycles in which no item moves on any channel
	localparam int STALL_LIMIT = 1000;

	localparam logic [DB_W-1:0]  FLOOR_LOWEST  = 12'(-2000);
	localparam logic [DB_W-1:0]  FLOOR_TOP     = 12'd0;
	localparam logic [FS_W-1:0]  FULL_SCALE_MAX = '1;

	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic [DB_W-1:0]    dbfs;
	} dbfs_expect_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [LEVEL_W-1:0]   s_tdata;   // [31:0] level_value
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [11:0] dbfs_tenths, [15:12] zero
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FS_W-1:0]      cfg_data;

	// register copies held by the predictor
	logic [FS_W-1:0]      full_scale_now = rmsdb_pkg::FS_RESET;
	logic [DB_W-1:0]      floor_now      = rmsdb_pkg::FLOOR_RESET;

	// predicted dBFS values, oldest first
	dbfs_expect_t         pending_dbfs[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_levels      = 0;
	int n_floor       = 0;
	int n_checked     = 0;
	int n_settings    = 0;
	int n_errors      = 0;
	int stall_cycles  = 0;

	rms_level_to_dbfs_tenths uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// log2 of a positive value: integer part is the top set bit, the fraction
	// comes from repeated squaring of a mantissa kept in [1, 2)
	function automatic logic [31:0] log2_q16(input logic [FS_W-1:0] v);
		int            msb;
		logic [63:0]   mant;
		logic [FRAC-1:0] frac;
		msb  = 0;
		frac = '0;
		for (int b = 0; b < FS_W; b++)
			if (v[b])
				msb = b;
		if (msb <= FRAC)
			mant = 64'(v) << (FRAC - msb);
		else
			mant = 64'(v) >> (msb - FRAC);
		for (int r = 0; r < FRAC; r++) begin
			mant = (mant * mant) >> FRAC;
			frac = frac << 1;
			// square reached 2.0: halve and record a one
			if (mant >= (64'd2 << FRAC)) begin
				mant    = mant >> 1;
				frac[0] = 1'b1;
			end
		end
		return (32'(msb) << FRAC) | 32'(frac);
	endfunction

	function automatic logic [DB_W-1:0] predict_dbfs(input logic [LEVEL_W-1:0] level);
		logic [31:0]     lv;
		logic [31:0]     lf;
		logic            below;
		longint unsigned mag;
		longint unsigned scaled;
		int              tenths;
		// zero, negative reading or zero full scale all give the floor as is
		if (level == '0 || level[LEVEL_W-1] || full_scale_now == '0)
			return floor_now;
		lv     = log2_q16(level[FS_W-1:0]);
		lf     = log2_q16(full_scale_now);
		below  = lv < lf;
		mag    = below ? 64'(lf - lv) : 64'(lv - lf);
		// round half up on the magnitude, then put the sign back
		scaled = (mag * DB10_PER_OCTAVE + DB10_SCALE / 2) / DB10_SCALE;
		tenths = below ? -int'(scaled) : int'(scaled);
		return tenths[DB_W-1:0];
	endfunction

	// One level item. Valid stays high on return so a back-to-back item does not
	// drop it; idling and the drain lower it.
	task automatic send_level(input logic [LEVEL_W-1:0] level);
		dbfs_expect_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= level;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		e.level = level;
		e.dbfs  = predict_dbfs(level);
		pending_dbfs.push_back(e);
		n_levels++;
		if (e.level == '0 || e.level[LEVEL_W-1] || full_scale_now == '0)
			n_floor++;
	endtask

	// hold the input off until every outstanding result has come back
	task automatic drain_results();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (pending_dbfs.size() != 0)
			@(posedge clk);
	endtask

	// Both registers, back to back. Only called with the pipeline empty and never
	// twice without items in between. Bits above the floor field get junk.
	task automatic set_config(input logic [FS_W-1:0] fs_value, input logic [DB_W-1:0] floor_db);
		cfg_valid <= 1'b1;
		cfg_index <= rmsdb_pkg::REG_FULL_SCALE;
		cfg_data  <= fs_value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		full_scale_now = fs_value;
		cfg_index <= rmsdb_pkg::REG_FLOOR;
		cfg_data  <= {19'($urandom), floor_db};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		floor_now = floor_db;
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [FS_W-1:0] random_full_scale();
		int              msb;
		logic [FS_W-1:0] v;
		case ($urandom_range(19))
			0: begin
				return 31'd1;
			end
			1: begin
				return FULL_SCALE_MAX;
			end
			2: begin
				return '0;
			end
			default: begin
				// spread evenly over octaves
				msb = $urandom_range(FS_W - 1);
				v   = 31'($urandom) & ((31'd1 << msb) - 31'd1);
				return v | (31'd1 << msb);
			end
		endcase
	endfunction

	function automatic logic [DB_W-1:0] random_floor();
		case ($urandom_range(9))
			0: begin
				return FLOOR_LOWEST;
			end
			1: begin
				return FLOOR_TOP;
			end
			2: begin
				// anything the register holds, stated range or not
				return 12'($urandom);
			end
			default: begin
				return 12'(-int'($urandom_range(2000)));
			end
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] random_level();
		int                 msb;
		logic [LEVEL_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				return $urandom;
			end
			1: begin
				return 32'(-int'($urandom_range(300)));
			end
			7: begin
				// close to full scale, around 0 dBFS
				return 32'(full_scale_now) + 32'($urandom_range(16)) - 32'd8;
			end
			8: begin
				msb = $urandom_range(LEVEL_W - 2);
				return (32'd1 << msb) + 32'($urandom_range(2)) - 32'd1;
			end
			9: begin
				return 32'($urandom_range(1, 300));
			end
			default: begin
				msb = $urandom_range(LEVEL_W - 2);
				v   = $urandom & ((32'd1 << msb) - 32'd1);
				return v | (32'd1 << msb);
			end
		endcase
	endfunction

	// values straight out of reset: full scale 32767, floor -1000
	task automatic test_reset_values();
		send_level(32'd32767);
		send_level(32'd0);
		send_level(32'd1);
		send_level(32'd16383);
	endtask

	// reading extremes against the reset full scale
	task automatic test_level_extremes();
		send_level(32'h7FFF_FFFF);
		send_level(32'h8000_0000);
		send_level(32'hFFFF_FFFF);
		send_level(32'd2);
		send_level(32'd32766);
		send_level(32'd32768);
		send_level(32'h0001_0000);
		send_level(32'h4000_0000);
	endtask

	// register extremes: full scale 1 and max, zero full scale, floor at both
	// ends of its range and beyond it
	task automatic test_register_extremes();
		drain_results();
		set_config(31'd1, FLOOR_LOWEST);
		send_level(32'h7FFF_FFFF);
		send_level(32'd1);
		send_level(32'd0);
		drain_results();
		set_config(FULL_SCALE_MAX, FLOOR_TOP);
		send_level(32'd1);
		send_level(32'h7FFF_FFFF);
		send_level(32'hFFFF_FFFB);
		drain_results();
		set_config('0, 12'h7FF);
		send_level(32'd12345);
		drain_results();
		set_config(31'd1234, 12'h800);
		send_level(32'hFFFF_FFF9);
		send_level(32'd1234);
	endtask

	// random readings in bursts, a fresh setting per burst and the odd drain
	task automatic test_random_levels(input int n_items, input int send_pct, input int recv_pct);
		int left;
		int burst;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		left          = n_items;
		while (left > 0) begin
			burst = $urandom_range(80, 200);
			if (burst > left)
				burst = left;
			drain_results();
			set_config(random_full_scale(), random_floor());
			for (int i = 0; i < burst; i++) begin
				send_level(random_level());
				if ($urandom_range(149) == 0)
					drain_results();
			end
			left -= burst;
		end
	endtask

	// result side: random backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result check and watchdog
	always @(posedge clk) begin
		dbfs_expect_t head;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_dbfs.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual dbfs_tenths %0d",
						$time, $signed(m_tdata[DB_W-1:0]));
					n_errors++;
				end else begin
					head = pending_dbfs.pop_front();
					n_checked++;
					if (m_tdata[DB_W-1:0] !== head.dbfs) begin
						$display("%0t: level %0d (full scale %0d): expected dbfs_tenths %0d, actual %0d",
							$time, $signed(head.level), full_scale_now,
							$signed(head.dbfs), $signed(m_tdata[DB_W-1:0]));
						n_errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: nothing moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending_dbfs.size());
				$display("rms_level_to_dbfs_tenths test failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rmsdb_pkg::REG_FULL_SCALE;
		cfg_data  = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// sender sparse, receiver stalling hard
		send_idle_pct = 32;
		recv_idle_pct = 85;
		test_reset_values();
		test_level_extremes();
		test_register_extremes();
		test_random_levels(540, 32, 85);
		// the other way round, then flat out
		test_random_levels(540, 85, 32);
		test_random_levels(540, 0, 0);

		drain_results();
		// anything the block still emits now has no item behind it
		repeat (FRAC + 10)
			@(posedge clk);

		$display("Checked %0d dBFS results from %0d level items, %0d of them on the floor path.",
			n_checked, n_levels, n_floor);
		$display("%0d register settings incl. zero/max full scale and out-of-range floors; %0s",
			n_settings, "three idling patterns.");
		if (n_errors == 0 && pending_dbfs.size() == 0) begin
			$display("rms_level_to_dbfs_tenths test passed");
		end else begin
			$display("rms_level_to_dbfs_tenths test failed");
		end
		$finish;
	end

endmodule
